[hw/rtl/ipd_frame_deframer_macros.svh]
// Assertion macros shared by the frame deframer RTL.
// Defining NO_ASSERTIONS compiles every check away.
`ifndef IPD_FRAME_DEFRAMER_MACROS_SVH
`define IPD_FRAME_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Whenever cond holds at a clock edge, expr must hold at the next edge.
`define IPD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("deframer check failed: next-cycle implication");

// The condition must never hold at a clock edge.
`define IPD_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("deframer check failed: forbidden condition");

`else

`define IPD_ASSERT_NEXT(label, clk, rst, cond, expr)
`define IPD_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[hw/rtl/ipdfd_pkg.sv]
// Types and constants for the +IPD frame deframer.
// No dependencies; used by ipd_frame_deframer.
package ipdfd_pkg;

   // Parser phases, one-hot.
   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_CHAN = 4'b0010,
      PH_LEN  = 4'b0100,
      PH_DATA = 4'b1000
   } phase_type;

   localparam int unsigned HDR_LEN = 5;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [7:0]  CHANNEL_TOP = 8'hFF;
   localparam logic [15:0] LENGTH_TOP  = 16'hFFFF;

   localparam logic [15:0] BUFCAP_RESET = 16'd2048;

   // Register index of buffer_capacity within the register map.
   localparam logic REG_BUFCAP = 1'b0;

   // Characters of the "+IPD," header in order.
   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h2B;
         3'd1:    ch = 8'h49;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h44;
         3'd4:    ch = 8'h2C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[hw/rtl/ipd_frame_deframer.sv]
// Top level of the +IPD frame deframer: byte stream in, payload stream out.
// Depends on ipdfd_pkg and ipd_frame_deframer_macros.svh.
`include "ipd_frame_deframer_macros.svh"

// The deframer takes one received byte per clock cycle unless the output holds
// it back, and emits at most one result per byte, only for bytes in the payload
// phase. A byte is captured in an input register, parsed against the
// header/field/payload state, and its result is loaded into the output register
// when the byte drains from the input register. The input register drains every
// cycle that the output register is free or being emptied (bytes outside the
// payload drain even when it is full), giving a sustained rate of one byte per
// cycle while the output is not back-pressured.
module ipd_frame_deframer
   import ipdfd_pkg::*;
#(
   parameter int unsigned FIELD_CHARS = 20
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                    // [31:24] channel, [47:32] frame_length
   output logic [1:0]  rsp_tuser,   // [0] data_valid, [1] fits_buffer
   output logic        rsp_tlast,   // frame_done

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned CW = $clog2(FIELD_CHARS + 1);
   localparam logic [CW-1:0] CHARS_MAX  = CW'(FIELD_CHARS);
   localparam logic [CW-1:0] CHARS_LOOK = CW'(FIELD_CHARS - 1);

   // Configuration register.
   logic [15:0] bufcap_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bufcap_ff <= BUFCAP_RESET;
      end else if (csr_write && csr_paddr[2] == REG_BUFCAP) begin
         bufcap_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_BUFCAP) ? {16'd0, bufcap_ff} : 32'd0;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       rsp_room;

   // Parser state.
   phase_type      phase_ff, phase_in;
   logic [2:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [CW-1:0]  chars_ff, chars_in;
   logic           ended_ff, ended_in;
   logic [7:0]     chan_ff, chan_in;
   logic [15:0]    len_ff, len_in;
   logic [15:0]    count_ff, count_in;

   // Output register.
   logic        rsp_valid_ff;
   logic        out_dvalid_ff, out_dvalid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [15:0] out_index_ff, out_index_in;
   logic        out_fits_ff, out_fits_in;
   logic        out_done_ff, out_done_in;
   logic [7:0]  out_chan_ff, out_chan_in;
   logic [15:0] out_len_ff, out_len_in;

   assign rsp_room   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (phase_ff != PH_DATA || rsp_room);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Decimal field accumulation, shared by the channel and length fields.
   logic        is_digit;
   logic [3:0]  digit;
   logic        take_en;
   logic [11:0] chan_prod;
   logic [19:0] len_prod;
   logic [7:0]  chan_acc;
   logic [15:0] len_acc;
   logic        acc_ended;
   logic [CW-1:0] acc_chars;
   logic [15:0] count_inc;

   assign is_digit = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign digit    = 4'(in_byte_ff - CHAR_ZERO);
   assign take_en  = (chars_ff < CHARS_LOOK) && !ended_ff;

   // Multiply by ten as 8x + 2x, then add the digit.
   assign chan_prod = {1'b0, chan_ff, 3'd0} + {3'd0, chan_ff, 1'b0} + {8'd0, digit};
   assign len_prod  = {1'b0, len_ff, 3'd0} + {3'd0, len_ff, 1'b0} + {16'd0, digit};

   always_comb begin
      chan_acc  = chan_ff;
      len_acc   = len_ff;
      acc_ended = ended_ff;
      if (take_en) begin
         if (is_digit) begin
            chan_acc = (chan_prod > {4'd0, CHANNEL_TOP}) ? CHANNEL_TOP : chan_prod[7:0];
            len_acc  = (len_prod > {4'd0, LENGTH_TOP}) ? LENGTH_TOP : len_prod[15:0];
         end else begin
            acc_ended = 1'b1;
         end
      end
      acc_chars = (chars_ff < CHARS_MAX) ? chars_ff + CW'(1) : chars_ff;
   end

   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      chars_in   = chars_ff;
      ended_in   = ended_ff;
      chan_in    = chan_ff;
      len_in     = len_ff;
      count_in   = count_ff;

      out_dvalid_in = 1'b0;
      out_byte_in   = 8'd0;
      out_index_in  = 16'd0;
      out_fits_in   = 1'b0;
      out_done_in   = 1'b0;
      out_chan_in   = 8'd0;
      out_len_in    = 16'd0;

      case (phase_ff)
         PH_HUNT: begin
            // A mismatching byte drops the count without being tried as '+'.
            if (in_byte_ff == hdr_char(hdr_cnt_ff)) begin
               if (hdr_cnt_ff == 3'(HDR_LEN - 1)) begin
                  hdr_cnt_in = 3'd0;
                  phase_in   = PH_CHAN;
                  chan_in    = 8'd0;
                  chars_in   = '0;
                  ended_in   = 1'b0;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
               end
            end else begin
               hdr_cnt_in = 3'd0;
            end
         end
         PH_CHAN: begin
            if (in_byte_ff == CHAR_COMMA) begin
               phase_in = PH_LEN;
               len_in   = 16'd0;
               chars_in = '0;
               ended_in = 1'b0;
            end else begin
               chan_in  = chan_acc;
               chars_in = acc_chars;
               ended_in = acc_ended;
            end
         end
         PH_LEN: begin
            if (in_byte_ff == CHAR_COLON) begin
               phase_in = PH_DATA;
               count_in = 16'd0;
               chars_in = '0;
               ended_in = 1'b0;
            end else begin
               len_in   = len_acc;
               chars_in = acc_chars;
               ended_in = acc_ended;
            end
         end
         PH_DATA: begin
            if (count_ff < len_ff) begin
               out_dvalid_in = 1'b1;
               out_byte_in   = in_byte_ff;
               out_index_in  = count_ff;
               out_fits_in   = count_ff < bufcap_ff;
               count_in      = count_inc;
            end
            // A zero-length frame ends on the byte after ':' with no payload.
            if (!(count_ff < len_ff) || count_inc == len_ff) begin
               out_done_in = 1'b1;
               out_chan_in = chan_ff;
               out_len_in  = len_ff;
               phase_in    = PH_HUNT;
               count_in    = 16'd0;
               hdr_cnt_in  = 3'd0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         hdr_cnt_ff <= 3'd0;
         chars_ff   <= '0;
         ended_ff   <= 1'b0;
         chan_ff    <= 8'd0;
         len_ff     <= 16'd0;
         count_ff   <= 16'd0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         chars_ff   <= chars_in;
         ended_ff   <= ended_in;
         chan_ff    <= chan_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
      end
   end

   logic rsp_load;
   assign rsp_load = advance && phase_ff == PH_DATA;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_dvalid_ff <= out_dvalid_in;
         out_byte_ff   <= out_byte_in;
         out_index_ff  <= out_index_in;
         out_fits_ff   <= out_fits_in;
         out_done_ff   <= out_done_in;
         out_chan_ff   <= out_chan_in;
         out_len_ff    <= out_len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_len_ff, out_chan_ff, out_index_ff, out_byte_ff};
   assign rsp_tuser  = {out_fits_ff, out_dvalid_ff};
   assign rsp_tlast  = out_done_ff;

   // Every processed payload byte must show up as a result in the next cycle.
   `IPD_ASSERT_NEXT(a_payload_gives_result, clock, reset, rsp_load, rsp_tvalid)
   // A result always carries a payload byte, a frame end, or both.
   `IPD_ASSERT_NEVER(a_result_not_empty, clock, reset,
                     rsp_tvalid && !rsp_tuser[0] && !rsp_tlast)
   // The payload counter is only live inside the payload phase.
   `IPD_ASSERT_NEVER(a_count_in_payload, clock, reset,
                     phase_ff != PH_DATA && count_ff != 16'd0)
   // Header matching progress exists only while hunting.
   `IPD_ASSERT_NEVER(a_hdr_in_hunt, clock, reset,
                     phase_ff != PH_HUNT && hdr_cnt_ff != 3'd0)

endmodule
